/* hw/rtl/ycr_pkg.sv */
// ----------------------------------------------------------------------------
// ycr_pkg
// Shared types and constants for the YCbCr to RGB upsampler.
// ----------------------------------------------------------------------------
package ycr_pkg;

  localparam int MAX_LINE_WIDTH_DEF = 4096;

  localparam int SAMPLE_W = 16;
  localparam int FMT_W    = 2;
  localparam int BITS_W   = 5;
  localparam int LWIDTH_W = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_ADDR_W = 2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CHROMA_FORMAT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_BITS   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH    = 2'd2;

  // chroma formats, the fourth code behaves as 4:2:0
  localparam logic [FMT_W-1:0] FMT_444 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_422 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_420 = 2'd2;

  localparam logic [FMT_W-1:0]    FORMAT_RESET = FMT_444;
  localparam logic [BITS_W-1:0]   BITS_RESET   = 5'd8;
  localparam logic [LWIDTH_W-1:0] WIDTH_RESET  = 13'd1920;

  // coefficients with 20 fractional bits
  localparam int FRAC_BITS = 20;
  localparam int COEF_W    = 22;
  localparam logic signed [COEF_W-1:0] K_RED     = 22'sd1470104;
  localparam logic signed [COEF_W-1:0] K_GREEN_B = 22'sd360710;
  localparam logic signed [COEF_W-1:0] K_GREEN_R = 22'sd748683;
  localparam logic signed [COEF_W-1:0] K_BLUE    = 22'sd1858077;

  typedef enum logic [1:0] {
    SRC_INPUT,
    SRC_STORE,
    SRC_HELD
  } chroma_src_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   luma;
    logic [SAMPLE_W-1:0]   cb;
    logic [SAMPLE_W-1:0]   cr;
    logic [2*SAMPLE_W-1:0] store_pair;  // cr in upper half, cb in lower half
    chroma_src_t           src;
  } ycr_item_t;

endpackage

/* hw/rtl/ycbcr_to_rgb_upsampler.sv */
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_upsampler
// BT.601 full range YCbCr to RGB conversion with 4:2:2 / 4:2:0 chroma reuse.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel per transaction in raster order; tdata carries luma,
//           Cb and Cr, tuser flags the first pixel of an image (resets the
//           column and row parity before that pixel).
//   out_* : one RGB pixel per input pixel, in the same order.
//   cfg_* : register writes (format, sample bits, line width), one per
//           cycle while cfg_we is high; the user writes only while the
//           block is idle, which the block itself does not enforce.
// Stages: input register with line store read, product register, result
//   register. Throughput: one pixel per clock while out_tready is high;
//   each of the three stages hands on its item as soon as the next one is
//   free, so bubbles are filled while the output is stalled and in_tready
//   drops only once all three stages hold pixels.
// Reset: pipeline emptied, position and held chroma cleared, registers back
//   to 4:4:4, 8 bits, 1920 pixels. No clearing pass for the line store: an
//   odd 4:2:0 row reads only entries the even row above has written.
// ----------------------------------------------------------------------------
module ycbcr_to_rgb_upsampler
  import ycr_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [3*SAMPLE_W-1:0] in_tdata,   // luma, chroma_blue, chroma_red
  input  logic                  in_tuser,   // start_of_image
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [3*SAMPLE_W-1:0] out_tdata,  // red, green, blue
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic [FMT_W-1:0]    fmt_r;
  logic [BITS_W-1:0]   bits_r;
  logic [LWIDTH_W-1:0] width_r;

  logic      a_valid_r, b_valid_r, c_valid_r;
  logic      a_ready, b_ready, c_ready;
  logic      take, a_adv, b_adv;
  ycr_item_t item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FORMAT_RESET;
      bits_r  <= BITS_RESET;
      width_r <= WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CHROMA_FORMAT: fmt_r   <= cfg_wdata[FMT_W-1:0];
        REG_SAMPLE_BITS:   bits_r  <= cfg_wdata[BITS_W-1:0];
        REG_LINE_WIDTH:    width_r <= cfg_wdata[LWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake, each stage loads when it is empty or drains
  assign c_ready   = ~c_valid_r | out_tready;
  assign b_ready   = ~b_valid_r | c_ready;
  assign a_ready   = ~a_valid_r | b_ready;
  assign in_tready = a_ready;
  assign take      = in_tvalid & a_ready;
  assign a_adv     = a_valid_r & b_ready;
  assign b_adv     = b_valid_r & c_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_tvalid;
      if (b_ready) b_valid_r <= a_valid_r;
      if (c_ready) c_valid_r <= b_valid_r;
    end
  end

  assign out_tvalid = c_valid_r;

  ycr_ctl #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .luma         (in_tdata[SAMPLE_W-1:0]),
    .cb           (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .cr           (in_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
    .sof          (in_tuser),
    .chroma_format(fmt_r),
    .line_width   (width_r),
    .item         (item)
  );

  ycr_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (a_adv),
    .item       (item),
    .prod_load  (a_adv),
    .out_load   (b_adv),
    .sample_bits(bits_r),
    .rgb        (out_tdata)
  );

endmodule

/* hw/rtl/ycr_ctl.sv */
// ----------------------------------------------------------------------------
// ycr_ctl
// Input register: column and row tracking, chroma source selection and the
// chroma line store for 4:2:0 odd rows.
// ----------------------------------------------------------------------------
module ycr_ctl
  import ycr_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,       // input transaction this cycle
  input  logic [SAMPLE_W-1:0] luma,
  input  logic [SAMPLE_W-1:0] cb,
  input  logic [SAMPLE_W-1:0] cr,
  input  logic                sof,
  input  logic [FMT_W-1:0]    chroma_format,
  input  logic [LWIDTH_W-1:0] line_width,
  output ycr_item_t           item
);

  localparam int CW          = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int STORE_DEPTH = (MAX_LINE_WIDTH + 1) / 2;
  localparam int SLOT_W      = (CW > 1) ? CW - 1 : 1;
  localparam int MW          = $clog2(MAX_LINE_WIDTH + 1);
  localparam int EW          = (MW > LWIDTH_W) ? MW : LWIDTH_W;
  localparam int CMPW        = (EW > CW + 1) ? EW : CW + 1;

  logic [CW-1:0]    col_r, col_nxt, col_cur;
  logic             odd_r, odd_nxt, odd_cur;
  logic [EW-1:0]    lw_ext, eff_width;
  logic [CMPW-1:0]  col_plus;
  logic             row_end;
  logic [CW-1:0]    slot_full;
  logic [SLOT_W-1:0] slot;
  logic             wr_en;
  chroma_src_t      src;
  logic [2*SAMPLE_W-1:0] store_mem [STORE_DEPTH];

  always_comb begin
    col_cur   = sof ? '0 : col_r;
    odd_cur   = sof ? 1'b0 : odd_r;
    slot_full = col_cur >> 1;
    slot      = slot_full[SLOT_W-1:0];

    lw_ext = EW'(line_width);
    if (lw_ext == '0) begin
      eff_width = EW'(1);
    end else if (lw_ext > EW'(MAX_LINE_WIDTH)) begin
      eff_width = EW'(MAX_LINE_WIDTH);
    end else begin
      eff_width = lw_ext;
    end
    col_plus = CMPW'(col_cur) + CMPW'(1);
    row_end  = col_plus >= CMPW'(eff_width);

    col_nxt = row_end ? '0 : col_plus[CW-1:0];
    odd_nxt = row_end ? ~odd_cur : odd_cur;

    wr_en = 1'b0;
    unique case (chroma_format)
      FMT_444: src = SRC_INPUT;
      FMT_422: src = col_cur[0] ? SRC_HELD : SRC_INPUT;
      default: begin
        if (odd_cur) begin
          src = SRC_STORE;
        end else begin
          src   = col_cur[0] ? SRC_HELD : SRC_INPUT;
          wr_en = ~col_cur[0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      odd_r <= 1'b0;
    end else if (take) begin
      col_r <= col_nxt;
      odd_r <= odd_nxt;
    end
  end

  // line store, written on even 4:2:0 rows, read data registered
  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      store_mem[slot] <= {cr, cb};
    end
    if (take) begin
      item.store_pair <= store_mem[slot];
      item.luma       <= luma;
      item.cb         <= cb;
      item.cr         <= cr;
      item.src        <= src;
    end
  end

endmodule

/* hw/rtl/ycr_conv.sv */
// ----------------------------------------------------------------------------
// ycr_conv
// Chroma pair selection, coefficient products and clamped RGB result register.
// ----------------------------------------------------------------------------
module ycr_conv
  import ycr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,    // item moves out of the input register
  input  ycr_item_t             item,
  input  logic                  prod_load,  // product register loads
  input  logic                  out_load,   // result register loads
  input  logic [BITS_W-1:0]     sample_bits,
  output logic [3*SAMPLE_W-1:0] rgb
);

  localparam int CH_W  = SAMPLE_W + 1;
  localparam int PW    = COEF_W + CH_W;
  localparam int SW    = PW + 1;
  localparam int QW    = FRAC_BITS;
  localparam int YW    = QW + 1;

  logic [2*SAMPLE_W-1:0] held_r, pair;
  logic [BITS_W-1:0]     bits_eff;
  logic signed [CH_W-1:0] offset, cbp, crp;
  logic signed [PW-1:0]  p_red_r, p_gb_r, p_gr_r, p_blue_r;
  logic [SAMPLE_W-1:0]   luma_r;
  logic signed [SW-1:0]  s_red, s_green, s_blue;
  logic signed [QW-1:0]  q_red, q_green, q_blue;
  logic signed [YW-1:0]  y_ext, v_red, v_green, v_blue;
  logic signed [YW-1:0]  upper;
  logic [SAMPLE_W-1:0]   r_c, g_c, b_c;

  function automatic logic signed [QW-1:0] trunc0(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] biased;
    biased = s + ((s < 0) ? SW'((1 << FRAC_BITS) - 1) : SW'(0));
    trunc0 = QW'(biased >>> FRAC_BITS);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clampv(input logic signed [YW-1:0] v,
                                                input logic signed [YW-1:0] up);
    logic [SAMPLE_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > up) begin
      res = up[SAMPLE_W-1:0];
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    clampv = res;
  endfunction

  always_comb begin
    if (sample_bits == '0) begin
      bits_eff = BITS_W'(1);
    end else if (sample_bits > BITS_W'(SAMPLE_W)) begin
      bits_eff = BITS_W'(SAMPLE_W);
    end else begin
      bits_eff = sample_bits;
    end
    offset = CH_W'(1) << (bits_eff - BITS_W'(1));
    upper  = (YW'(1) << bits_eff) - YW'(1);

    unique case (item.src)
      SRC_INPUT: pair = {item.cr, item.cb};
      SRC_STORE: pair = item.store_pair;
      default:   pair = held_r;
    endcase
    cbp = $signed({1'b0, pair[SAMPLE_W-1:0]}) - offset;
    crp = $signed({1'b0, pair[2*SAMPLE_W-1:SAMPLE_W]}) - offset;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (advance) begin
      held_r <= pair;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_load) begin
      luma_r   <= item.luma;
      p_red_r  <= PW'(K_RED) * PW'(crp);
      p_gb_r   <= PW'(K_GREEN_B) * PW'(cbp);
      p_gr_r   <= PW'(K_GREEN_R) * PW'(crp);
      p_blue_r <= PW'(K_BLUE) * PW'(cbp);
    end
  end

  always_comb begin
    s_red   = SW'(p_red_r);
    s_green = SW'(p_gb_r) + SW'(p_gr_r);
    s_blue  = SW'(p_blue_r);
    q_red   = trunc0(s_red);
    q_green = trunc0(s_green);
    q_blue  = trunc0(s_blue);
    y_ext   = $signed(YW'(luma_r));
    v_red   = y_ext + YW'(q_red);
    v_green = y_ext - YW'(q_green);
    v_blue  = y_ext + YW'(q_blue);
    r_c     = clampv(v_red, upper);
    g_c     = clampv(v_green, upper);
    b_c     = clampv(v_blue, upper);
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rgb <= {b_c, g_c, r_c};
    end
  end

endmodule
